/* hw/rtl/sgre_pkg.sv */
`default_nettype none

package sgre_pkg;

  // default beam index width
  localparam int BEAM_INDEX_BITS_DEF = 10;

  localparam int RANGE_W  = 16;
  localparam int OFFSET_W = 11;
  localparam int CFG_BEAM_W = 10;

  // register map, word index
  localparam logic [1:0] REG_RANGE_LIMIT   = 2'd0;
  localparam logic [1:0] REG_GAP_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_FIRST_BEAM    = 2'd2;
  localparam logic [1:0] REG_CENTER_BEAM   = 2'd3;

  // register reset values
  localparam logic [RANGE_W-1:0]    RANGE_LIMIT_RST   = 16'd4000;
  localparam logic [RANGE_W-1:0]    GAP_THRESHOLD_RST = 16'd500;
  localparam logic [CFG_BEAM_W-1:0] FIRST_BEAM_RST    = 10'd120;
  localparam logic [CFG_BEAM_W-1:0] CENTER_BEAM_RST   = 10'd360;

  // saturation bounds of a beam offset
  localparam int OFFSET_MAX = 1023;
  localparam int OFFSET_MIN = -1024;

  typedef struct packed {
    logic                       region_valid;
    logic signed [OFFSET_W-1:0] start_beam_offset;
    logic [RANGE_W-1:0]         start_depth_mm;
    logic signed [OFFSET_W-1:0] end_beam_offset;
    logic [RANGE_W-1:0]         end_depth_mm;
    logic                       scan_done;
  } result_t;

  // edge tracking state carried from sample to sample
  typedef struct packed {
    logic [RANGE_W-1:0]         previous_range;
    logic signed [OFFSET_W-1:0] held_edge_offset;
    logic [RANGE_W-1:0]         held_edge_depth;
    logic                       held_edge_rising;
    logic                       edge_seen;
    logic                       window_open;
  } track_t;

  typedef struct packed {
    logic [RANGE_W-1:0]    range_limit;
    logic [RANGE_W-1:0]    gap_threshold;
    logic [CFG_BEAM_W-1:0] first_beam;
    logic [CFG_BEAM_W-1:0] center_beam;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/sgre_step.sv */
`default_nettype none

module sgre_step #(
  parameter int BEAM_INDEX_BITS = sgre_pkg::BEAM_INDEX_BITS_DEF
) (
  input  var sgre_pkg::cfg_t            cfg,
  input  var sgre_pkg::track_t          track,
  input  wire [BEAM_INDEX_BITS-1:0]     beam,
  input  wire [sgre_pkg::RANGE_W-1:0]   range_mm,
  input  wire                           window_end,
  output sgre_pkg::track_t              track_next,
  output logic [1:0]                    n_results,
  output sgre_pkg::result_t             res0,
  output sgre_pkg::result_t             res1
);

  localparam int DIFF_W = 14;

  function automatic logic signed [sgre_pkg::OFFSET_W-1:0] beam_off(
    input logic [BEAM_INDEX_BITS-1:0]      b,
    input logic [sgre_pkg::CFG_BEAM_W-1:0] c
  );
    logic signed [DIFF_W-1:0] d;
    d = signed'(DIFF_W'(b)) - signed'(DIFF_W'(c));
    if (d > DIFF_W'(sgre_pkg::OFFSET_MAX)) begin
      return sgre_pkg::OFFSET_W'(sgre_pkg::OFFSET_MAX);
    end else if (d < DIFF_W'(sgre_pkg::OFFSET_MIN)) begin
      return sgre_pkg::OFFSET_W'(sgre_pkg::OFFSET_MIN);
    end
    return d[sgre_pkg::OFFSET_W-1:0];
  endfunction

  logic [sgre_pkg::RANGE_W-1:0]         r;
  logic [sgre_pkg::RANGE_W-1:0]         diff;
  logic                                 is_edge;
  logic                                 rising;
  logic                                 emit;
  logic                                 close;
  logic signed [sgre_pkg::OFFSET_W-1:0] off_here;
  logic signed [sgre_pkg::OFFSET_W-1:0] off_prev;
  logic signed [sgre_pkg::OFFSET_W-1:0] eoff;
  sgre_pkg::track_t                     t;
  sgre_pkg::result_t                    emit_res;
  sgre_pkg::result_t                    close_res;
  sgre_pkg::result_t                    marker;

  assign r        = (range_mm > cfg.range_limit) ? cfg.range_limit : range_mm;
  assign off_here = beam_off(beam, cfg.center_beam);
  assign off_prev = beam_off(beam - BEAM_INDEX_BITS'(1), cfg.center_beam);
  assign diff     = (track.previous_range > r) ? track.previous_range - r
                                               : r - track.previous_range;
  assign rising   = track.previous_range < r;
  assign is_edge  = track.window_open && (diff > cfg.gap_threshold);
  assign eoff     = rising ? off_prev : off_here;
  assign emit     = is_edge && (track.edge_seen ? (track.held_edge_rising || !rising)
                                                : !rising);

  always_comb begin
    t = track;
    if (!track.window_open) begin
      t.window_open      = 1'b1;
      t.held_edge_offset = off_here;
      t.held_edge_depth  = r;
      t.held_edge_rising = 1'b0;
      t.edge_seen        = 1'b0;
    end else if (is_edge) begin
      t.held_edge_offset = eoff;
      t.held_edge_depth  = track.previous_range;
      t.held_edge_rising = rising;
      t.edge_seen        = 1'b1;
    end
    t.previous_range = r;
    if (window_end) begin
      t.window_open      = 1'b0;
      t.edge_seen        = 1'b0;
      t.held_edge_rising = 1'b0;
    end
  end

  assign track_next = t;

  // region closed by the end boundary
  always_comb begin
    close = window_end && (!t.edge_seen || t.held_edge_rising);
    // t.edge_seen/held_edge_rising were cleared above on window end, recompute
    if (window_end) begin
      if (!track.window_open) begin
        close = 1'b1;
      end else if (is_edge) begin
        close = rising;
      end else begin
        close = !track.edge_seen || track.held_edge_rising;
      end
    end
  end

  always_comb begin
    emit_res = '{region_valid: 1'b1,
                 start_beam_offset: track.held_edge_offset,
                 start_depth_mm: track.held_edge_depth,
                 end_beam_offset: eoff,
                 end_depth_mm: track.previous_range,
                 scan_done: 1'b0};
    close_res = '{region_valid: 1'b1,
                  start_beam_offset: t.held_edge_offset,
                  start_depth_mm: t.held_edge_depth,
                  end_beam_offset: off_here,
                  end_depth_mm: r,
                  scan_done: 1'b1};
    marker = '0;
    marker.scan_done = 1'b1;

    res0 = emit_res;
    res1 = close_res;
    n_results = 2'd0;
    if (emit && close) begin
      n_results = 2'd2;
    end else if (emit) begin
      n_results = 2'd1;
      res0.scan_done = window_end;
    end else if (close) begin
      n_results = 2'd1;
      res0 = close_res;
    end else if (window_end) begin
      n_results = 2'd1;
      res0 = marker;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/scan_gap_region_extractor_core.sv */
`default_nettype none

// scan gap region extractor: takes the laser range samples of one scan window in
// beam order (s_tdata = range in mm, s_tlast on the window's last sample), clamps
// each to range_limit, marks a jump above gap_threshold between neighbors as an
// edge and emits the free regions between edges as start/end beam offsets from
// center_beam with their depths. one sample is accepted per clock; the sample is
// evaluated in the cycle it is taken and its results land in a four-entry result
// queue, which drains one region request per cycle. a sample that closes two regions
// (an edge on the window's last sample) pushes two requests, so the sustained rate
// is one sample per cycle as long as the sink keeps up; the input stalls only when
// fewer than two queue entries are free. every window ends with exactly one request
// carrying m_tlast (a bare marker with m_tuser low when no region closes). the user
// must write configuration over apb while the block is idle; that is not enforced.
module scan_gap_region_extractor_core #(
  parameter int BEAM_INDEX_BITS = sgre_pkg::BEAM_INDEX_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  // sample stream
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [15:0] s_tdata,   // [15:0] range_mm
  input  wire        s_tlast,   // window_end
  // region stream
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [55:0] m_tdata,  // [10:0] start_beam_offset, [26:11] start_depth_mm,
                                // [37:27] end_beam_offset, [53:38] end_depth_mm, pad
  output logic       m_tlast,   // scan_done
  output logic       m_tuser,   // region_valid
  // configuration
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [3:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // configuration registers
  sgre_pkg::cfg_t cfg;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_limit   <= sgre_pkg::RANGE_LIMIT_RST;
      cfg.gap_threshold <= sgre_pkg::GAP_THRESHOLD_RST;
      cfg.first_beam    <= sgre_pkg::FIRST_BEAM_RST;
      cfg.center_beam   <= sgre_pkg::CENTER_BEAM_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sgre_pkg::REG_RANGE_LIMIT:   cfg.range_limit   <= pwdata[15:0];
        sgre_pkg::REG_GAP_THRESHOLD: cfg.gap_threshold <= pwdata[15:0];
        sgre_pkg::REG_FIRST_BEAM:    cfg.first_beam    <= pwdata[9:0];
        sgre_pkg::REG_CENTER_BEAM:   cfg.center_beam   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sgre_pkg::REG_RANGE_LIMIT:   prdata = {16'd0, cfg.range_limit};
      sgre_pkg::REG_GAP_THRESHOLD: prdata = {16'd0, cfg.gap_threshold};
      sgre_pkg::REG_FIRST_BEAM:    prdata = {22'd0, cfg.first_beam};
      sgre_pkg::REG_CENTER_BEAM:   prdata = {22'd0, cfg.center_beam};
      default:                     prdata = '0;
    endcase
  end

  // edge tracking state and beam counter
  sgre_pkg::track_t             track;
  sgre_pkg::track_t             track_next;
  logic [BEAM_INDEX_BITS-1:0]   beam_counter;
  logic [1:0]                   n_results;
  sgre_pkg::result_t            res0;
  sgre_pkg::result_t            res1;
  logic                         in_take;

  assign in_take = s_tvalid && s_tready;

  sgre_step #(
    .BEAM_INDEX_BITS(BEAM_INDEX_BITS)
  ) u_step (
    .cfg        (cfg),
    .track      (track),
    .beam       (beam_counter),
    .range_mm   (s_tdata),
    .window_end (s_tlast),
    .track_next (track_next),
    .n_results  (n_results),
    .res0       (res0),
    .res1       (res1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      track        <= '0;
      beam_counter <= BEAM_INDEX_BITS'(sgre_pkg::FIRST_BEAM_RST);
    end else if (in_take) begin
      track <= track_next;
      // the counter restarts at first_beam once a window closes
      if (s_tlast) begin
        beam_counter <= BEAM_INDEX_BITS'(cfg.first_beam);
      end else begin
        beam_counter <= beam_counter + BEAM_INDEX_BITS'(1);
      end
    end
  end

  // result queue: up to two pushes per sample, one pop per cycle
  sgre_pkg::result_t q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic [1:0]        n_push;
  logic              pop;

  assign n_push   = in_take ? n_results : 2'd0;
  assign pop      = m_tvalid && m_tready;
  // room for the worst case of two results
  assign s_tready = count <= (QPTR_W + 1)'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q[wr_ptr] <= res0;
    end
    if (n_push == 2'd2) begin
      q[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W + 1)'(n_push) - (QPTR_W + 1)'(pop);
    end
  end

  sgre_pkg::result_t head;

  assign head     = q[rd_ptr];
  assign m_tvalid = count != '0;
  assign m_tuser  = head.region_valid;
  assign m_tlast  = head.scan_done;
  assign m_tdata  = {2'b00, head.end_depth_mm, head.end_beam_offset,
                     head.start_depth_mm, head.start_beam_offset};

endmodule

`default_nettype wire
